@@ rtl/core/mme_pkg.sv @@
// Shared widths, codes, types and helpers for the matrix multiply engine.
package mme_pkg;

   localparam int MAX_DIM   = 8;
   localparam int FRAC_BITS = 8;

   localparam int OP_W    = 2;
   localparam int IDX_W   = 3;
   localparam int ELEM_W  = 16;
   localparam int CSR_W   = 4;
   localparam int CSR_IDX_W = 2;
   localparam int DEPTH   = MAX_DIM * MAX_DIM;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int PROD_W  = 2 * ELEM_W;
   localparam int ACC_W   = PROD_W + $clog2(MAX_DIM) + 1;

   localparam logic [CSR_W-1:0] MAX_DIM_V  = CSR_W'(MAX_DIM);
   localparam logic [CSR_W-1:0] CFG_RESET  = 4'd8;
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'((1 << FRAC_BITS) >> 1);
   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
   localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(32768);

   typedef enum logic [OP_W-1:0] {
      OP_LOAD_A  = 2'd0,
      OP_LOAD_B  = 2'd1,
      OP_COMPUTE = 2'd2
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROWS_A = 2'd0,
      CSR_COLS_A = 2'd1,
      CSR_ROWS_B = 2'd2,
      CSR_COLS_B = 2'd3
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_FETCH  = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_OUTPUT = 4'b1000
   } state_type;

   // Tags that travel with each term through the multiply-accumulate pipeline.
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } mac_ctl_type;

   function automatic logic [CSR_W-1:0] eff_dim(input logic [CSR_W-1:0] v);
      logic [CSR_W-1:0] r;
      r = v;
      if (v == '0) r = CSR_W'(1);
      else if (v > MAX_DIM_V) r = MAX_DIM_V;
      return r;
   endfunction

   function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] row,
                                                   input logic [IDX_W-1:0] col);
      return ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_DIM) + ADDR_W'(col));
   endfunction

endpackage

@@ rtl/core/mme_mac.sv @@
// Shared multiply-accumulate unit with rounding and saturation of the sum.
module mme_mac (
   input  logic                                clock,
   input  logic                                reset,
   input  mme_pkg::mac_ctl_type                mac_ctl,
   input  logic signed [mme_pkg::ELEM_W-1:0]   a_data,
   input  logic signed [mme_pkg::ELEM_W-1:0]   b_data,
   output logic signed [mme_pkg::ELEM_W-1:0]   sum_value,
   output logic                                sum_done
);
   import mme_pkg::*;

   mac_ctl_type               prod_ctl_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [ACC_W-1:0]   acc_in;
   logic                      done_ff;
   logic                      done_in;
   logic signed [ACC_W-1:0]   rounded;
   logic signed [ACC_W-1:0]   shifted;

   assign prod_in = PROD_W'(a_data) * PROD_W'(b_data);
   assign acc_in  = prod_ctl_ff.first ? ACC_W'(prod_ff) : acc_ff + ACC_W'(prod_ff);
   assign done_in = prod_ctl_ff.valid && prod_ctl_ff.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_ctl_ff <= '0;
         done_ff     <= 1'b0;
      end else begin
         prod_ctl_ff <= mac_ctl;
         done_ff     <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (prod_ctl_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   // Round to nearest with ties upward: add half an LSB, then floor.
   always_comb begin
      rounded = acc_ff + ROUND_HALF;
      shifted = rounded >>> FRAC_BITS;
      if (shifted > SAT_HI) sum_value = SAT_HI[ELEM_W-1:0];
      else if (shifted < SAT_LO) sum_value = SAT_LO[ELEM_W-1:0];
      else sum_value = shifted[ELEM_W-1:0];
   end

   assign sum_done = done_ff;

endmodule

@@ rtl/core/matrix_multiply_engine_core.sv @@
// Top level of the matrix multiply engine: element stores, sequencer and result register.
// Load requests write one element of A or B. A compute request
// checks that the columns of A match the rows of B and then produces rows_a * cols_b
// results in row-major order, each the dot product over the inner dimension K,
// rounded to Q8.8 and saturated. For each result, K element pairs are read through
// the single read port of each element store into one shared multiply-accumulate
// unit; the sum then drains through the read, product and accumulate registers and
// is loaded into the result register. A dimension mismatch loads one error result,
// marked last, from the output state. No request is taken while a compute runs.
// Both stores read as zero after reset until an element is loaded.
module matrix_multiply_engine_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [mme_pkg::OP_W-1:0]           req_operation,
   input  logic [mme_pkg::IDX_W-1:0]          req_elem_row,
   input  logic [mme_pkg::IDX_W-1:0]          req_elem_col,
   input  logic signed [mme_pkg::ELEM_W-1:0]  req_elem_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [mme_pkg::ELEM_W-1:0]  rsp_product_value,
   output logic [mme_pkg::IDX_W-1:0]          rsp_out_row,
   output logic [mme_pkg::IDX_W-1:0]          rsp_out_col,
   output logic                               rsp_dim_error,
   output logic                               rsp_last_result,
   input  logic                               csr_write_enable,
   input  logic [mme_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mme_pkg::CSR_W-1:0]          csr_write_data
);
   import mme_pkg::*;

   logic [CSR_W-1:0]          rows_a_ff, cols_a_ff, rows_b_ff, cols_b_ff;
   logic [CSR_W-1:0]          ra_eff, ca_eff, rb_eff, cb_eff;

   logic [ELEM_W-1:0]         mem_a [DEPTH];
   logic [ELEM_W-1:0]         mem_b [DEPTH];
   logic [DEPTH-1:0]          vld_a_ff, vld_b_ff;
   logic [ELEM_W-1:0]         rd_a_ff, rd_b_ff;
   logic                      rd_vld_a_ff, rd_vld_b_ff;
   mac_ctl_type               rd_ctl_ff;
   mac_ctl_type               rd_ctl_in;

   state_type                 state_ff, state_in;
   logic [IDX_W-1:0]          h_ff, h_in, i_ff, i_in, j_ff, j_in;
   logic                      err_ff, err_in;

   logic                      req_accept;
   logic                      load_ok;
   logic [ADDR_W-1:0]         wr_addr;
   logic [ADDR_W-1:0]         rd_addr_a, rd_addr_b;
   logic                      fetch_last;
   logic                      row_last, col_last;

   logic signed [ELEM_W-1:0]  a_data, b_data;
   logic signed [ELEM_W-1:0]  sum_value;
   logic                      sum_done;

   logic                      out_free;
   logic                      out_load;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [ELEM_W-1:0]  rsp_value_ff;
   logic [IDX_W-1:0]          rsp_row_ff, rsp_col_ff;
   logic                      rsp_err_ff, rsp_last_ff;

   assign ra_eff = eff_dim(rows_a_ff);
   assign ca_eff = eff_dim(cols_a_ff);
   assign rb_eff = eff_dim(rows_b_ff);
   assign cb_eff = eff_dim(cols_b_ff);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff <= CFG_RESET;
         cols_a_ff <= CFG_RESET;
         rows_b_ff <= CFG_RESET;
         cols_b_ff <= CFG_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_idx_type'(csr_index))
            CSR_ROWS_A: rows_a_ff <= csr_write_data;
            CSR_COLS_A: cols_a_ff <= csr_write_data;
            CSR_ROWS_B: rows_b_ff <= csr_write_data;
            CSR_COLS_B: cols_b_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign load_ok    = ({1'b0, req_elem_row} < MAX_DIM_V) && ({1'b0, req_elem_col} < MAX_DIM_V);
   assign wr_addr    = elem_addr(req_elem_row, req_elem_col);
   assign rd_addr_a  = elem_addr(h_ff, j_ff);
   assign rd_addr_b  = elem_addr(j_ff, i_ff);
   assign fetch_last = ({1'b0, j_ff} + CSR_W'(1)) == ca_eff;
   assign row_last   = ({1'b0, h_ff} + CSR_W'(1)) == ra_eff;
   assign col_last   = ({1'b0, i_ff} + CSR_W'(1)) == cb_eff;

   // Element stores; an entry never loaded since reset reads as zero.
   always_ff @(posedge clock) begin
      if (req_accept && load_ok && (op_type'(req_operation) == OP_LOAD_A)) begin
         mem_a[wr_addr] <= req_elem_value;
      end
      if (req_accept && load_ok && (op_type'(req_operation) == OP_LOAD_B)) begin
         mem_b[wr_addr] <= req_elem_value;
      end
      if (state_ff == ST_FETCH) begin
         rd_a_ff     <= mem_a[rd_addr_a];
         rd_b_ff     <= mem_b[rd_addr_b];
         rd_vld_a_ff <= vld_a_ff[rd_addr_a];
         rd_vld_b_ff <= vld_b_ff[rd_addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= '0;
         vld_b_ff <= '0;
      end else if (req_accept && load_ok) begin
         if (op_type'(req_operation) == OP_LOAD_A) vld_a_ff[wr_addr] <= 1'b1;
         if (op_type'(req_operation) == OP_LOAD_B) vld_b_ff[wr_addr] <= 1'b1;
      end
   end

   assign a_data = rd_vld_a_ff ? rd_a_ff : '0;
   assign b_data = rd_vld_b_ff ? rd_b_ff : '0;

   always_comb begin
      rd_ctl_in.valid = (state_ff == ST_FETCH);
      rd_ctl_in.first = (j_ff == '0);
      rd_ctl_in.last  = fetch_last;
   end

   mme_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .mac_ctl   (rd_ctl_ff),
      .a_data    (a_data),
      .b_data    (b_data),
      .sum_value (sum_value),
      .sum_done  (sum_done)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign out_load = (state_ff == ST_OUTPUT) && out_free;

   // Sequencer: walk h (rows of A), i (columns of B), j (inner dimension).
   always_comb begin
      state_in = state_ff;
      h_in     = h_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      err_in   = err_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (op_type'(req_operation) == OP_COMPUTE)) begin
               h_in   = '0;
               i_in   = '0;
               j_in   = '0;
               err_in = (ca_eff != rb_eff);
               state_in = (ca_eff != rb_eff) ? ST_OUTPUT : ST_FETCH;
            end
         end
         ST_FETCH: begin
            if (fetch_last) begin
               state_in = ST_DRAIN;
            end else begin
               j_in = j_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            if (sum_done) begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (out_free) begin
               j_in = '0;
               if (err_ff || (row_last && col_last)) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_FETCH;
                  if (col_last) begin
                     i_in = '0;
                     h_in = h_ff + IDX_W'(1);
                  end else begin
                     i_in = i_ff + IDX_W'(1);
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rd_ctl_ff <= '0;
      end else begin
         state_ff  <= state_in;
         rd_ctl_ff <= rd_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      h_ff   <= h_in;
      i_ff   <= i_in;
      j_ff   <= j_in;
      err_ff <= err_in;
   end

   // Result register.
   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_value_ff <= err_ff ? '0 : sum_value;
         rsp_row_ff   <= err_ff ? '0 : h_ff;
         rsp_col_ff   <= err_ff ? '0 : i_ff;
         rsp_err_ff   <= err_ff;
         rsp_last_ff  <= err_ff || (row_last && col_last);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_product_value = rsp_value_ff;
   assign rsp_out_row       = rsp_row_ff;
   assign rsp_out_col       = rsp_col_ff;
   assign rsp_dim_error     = rsp_err_ff;
   assign rsp_last_result   = rsp_last_ff;

`ifndef SYNTHESIS
   a_err_result_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dim_error |-> rsp_last_result && (rsp_product_value == '0))
      else $error("error result is not a lone zero result");

   a_done_in_drain: assert property (@(posedge clock) disable iff (reset)
      sum_done |-> (state_ff == ST_DRAIN))
      else $error("accumulator finished outside the drain phase");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_dim_error |-> ({1'b0, rsp_out_row} < ra_eff))
      else $error("result row beyond the rows of A");
`endif

endmodule
